/* hw/rtl/mexp_pkg.sv */
// Shared constants for the modular exponentiation core.
package mexp_pkg;

	localparam int DEF_WIDTH = 32;

	// Modulus value after reset
	localparam int unsigned MODULUS_RESET = 2;

endpackage

/* hw/rtl/mexp_if.sv */
// Valid/ready channels of the modular exponentiation core.
interface mexp_op_if #(
	parameter int WIDTH = mexp_pkg::DEF_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] base;
	logic [WIDTH-1:0] exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_res_if #(
	parameter int WIDTH = mexp_pkg::DEF_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

/* hw/rtl/modular_exponentiation_core.sv */
// Top level: right-to-left square-and-multiply modular exponentiation.
//
//  channel   dir   payload               handshake
//  op        in    base, exponent        valid/ready
//  res       out   result                valid/ready
//  modulus   cfg   modulus_wdata         modulus_we
//
// One shared bit-serial multiplier does all work. An item costs a base reduction plus,
// per exponent bit up to the highest set one, a step state, a multiply where the bit
// is set and a square below the highest set bit; the core accepts the next item only
// after the current one has left for the output register.
// Reset sets the modulus to 2; a result waiting in the output register does not
// block the next item, and a stalled output holds the finished result until it moves.
module modular_exponentiation_core #(
	parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             modulus_we,
	input  logic [WIDTH-1:0] modulus_wdata,
	mexp_op_if.sink          op,
	mexp_res_if.source       res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_STEP,
		ST_MULA,
		ST_SQR,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] e_q;
	logic             res_valid_q;
	logic [WIDTH-1:0] result_q;

	logic             mm_start;
	logic [WIDTH-1:0] mm_x;
	logic [WIDTH-1:0] mm_y;
	logic             mm_busy;
	logic             mm_done;
	logic [WIDTH-1:0] mm_prod;
	logic [WIDTH-1:0] one_mod;
	logic             op_acc;
	logic             e_high_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WIDTH'(mexp_pkg::MODULUS_RESET);
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	assign one_mod     = (modulus_q == WIDTH'(1)) ? '0 : WIDTH'(1);
	assign op_acc      = op.valid && op.ready;
	assign e_high_zero = (e_q[WIDTH-1:1] == '0);

	// Issue the next product; operands come from the state that starts it
	always_comb begin
		mm_start = 1'b0;
		mm_x     = sq_q;
		mm_y     = sq_q;
		unique case (state_q)
			ST_IDLE: begin
				mm_start = op_acc && (modulus_q != '0);
				mm_x     = one_mod;
				mm_y     = op.base;
			end
			ST_STEP: begin
				mm_start = (e_q != '0);
				if (e_q[0]) begin
					mm_x = acc_q;
				end
			end
			ST_MULA: begin
				mm_start = mm_done && !e_high_zero;
			end
			ST_RED, ST_SQR, ST_DONE: begin
				mm_start = 1'b0;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	mexp_modmul #(
		.WIDTH(WIDTH)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.m     (modulus_q),
		.busy  (mm_busy),
		.done  (mm_done),
		.prod  (mm_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			acc_q       <= '0;
			sq_q        <= '0;
			e_q         <= '0;
			result_q    <= '0;
		end else begin
			// Drop the taken item; a finished item reloads the register instead
			if (res_valid_q && res.ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_acc) begin
						e_q <= op.exponent;
						if (modulus_q == '0) begin
							acc_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							acc_q   <= one_mod;
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mm_done) begin
						sq_q    <= mm_prod;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (e_q == '0) begin
						state_q <= ST_DONE;
					end else if (e_q[0]) begin
						state_q <= ST_MULA;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MULA: begin
					if (mm_done) begin
						acc_q <= mm_prod;
						// Skip the square when no higher exponent bit remains
						if (e_high_zero) begin
							e_q     <= '0;
							state_q <= ST_STEP;
						end else begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					if (mm_done) begin
						sq_q    <= mm_prod;
						e_q     <= {1'b0, e_q[WIDTH-1:1]};
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						result_q    <= acc_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign op.ready   = (state_q == ST_IDLE);
	assign res.valid  = res_valid_q;
	assign res.result = result_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_busy)
		else $error("multiplier started while busy");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_RED || state_q == ST_MULA || state_q == ST_SQR))
		else $error("product finished with no state waiting for it");

	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> (!mm_busy && !mm_done))
		else $error("multiplier active outside of an item");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !res_valid_q) |=> res_valid_q && state_q == ST_IDLE)
		else $error("finished result not moved to output register");

endmodule

/* hw/rtl/mexp_modmul.sv */
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
module mexp_modmul #(
	parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	input  logic [WIDTH-1:0] m,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] prod
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;

	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] red1;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] red2;
	logic [WIDTH-1:0] acc_nxt;

	// Double, reduce, then add x and reduce when the current bit of y is set
	always_comb begin
		dbl  = {1'b0, acc_q} + {1'b0, acc_q};
		red1 = (dbl >= {1'b0, m}) ? WIDTH'(dbl - {1'b0, m}) : dbl[WIDTH-1:0];
		sum  = {1'b0, red1} + {1'b0, x_q};
		red2 = (sum >= {1'b0, m}) ? WIDTH'(sum - {1'b0, m}) : sum[WIDTH-1:0];
		acc_nxt = y_q[WIDTH-1] ? red2 : red1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			y_q   <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

/* bench/modular_exponentiation_core_tb.sv */
// Testbench for the modular exponentiation core: directed and random items, self-checking.
`timescale 1ns / 1ps

module modular_exponentiation_core_tb;

	localparam int WIDTH = mexp_pkg::DEF_WIDTH;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int OUTPUT_HOLD_CYCLES = 8000;
	localparam int DRAIN_CYCLES = 2200;
	localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
	localparam logic [WIDTH-1:0] PRIME_32 = 32'hFFFF_FFFB;

	logic clk = 1'b0;
	logic arst_n;
	logic modulus_we;
	logic [WIDTH-1:0] modulus_wdata;

	mexp_op_if #(.WIDTH(WIDTH)) op_ch ();
	mexp_res_if #(.WIDTH(WIDTH)) res_ch ();

	modular_exponentiation_core #(.WIDTH(WIDTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.modulus_we(modulus_we),
		.modulus_wdata(modulus_wdata),
		.op(op_ch),
		.res(res_ch)
	);

	logic [WIDTH-1:0] active_modulus;
	logic [WIDTH-1:0] expected_powers[$];
	logic [WIDTH-1:0] oldest_power;
	int error_count = 0;
	int stuck_cycles = 0;
	int hold_requests = 0;
	bit input_gaps;
	bit output_stalls;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Right-to-left square-and-multiply, every step reduced modulo m.
	function automatic logic [WIDTH-1:0] predict_power(input logic [WIDTH-1:0] b,
			input logic [WIDTH-1:0] e, input logic [WIDTH-1:0] m);
		logic [2*WIDTH-1:0] acc;
		logic [2*WIDTH-1:0] sq;
		logic [2*WIDTH-1:0] m_wide;
		if (m == '0) begin
			return '0;
		end
		m_wide = {{WIDTH{1'b0}}, m};
		acc = 1 % m_wide;
		sq = {{WIDTH{1'b0}}, b} % m_wide;
		for (int i = 0; i < WIDTH; i++) begin
			if (e[i]) begin
				acc = (acc * sq) % m_wide;
			end
			sq = (sq * sq) % m_wide;
		end
		return acc[WIDTH-1:0];
	endfunction

	task automatic send_operation(input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] e);
		op_ch.valid <= 1'b1;
		op_ch.base <= b;
		op_ch.exponent <= e;
		@(posedge clk);
		while (!op_ch.ready) begin
			@(posedge clk);
		end
		expected_powers.push_back(predict_power(b, e, active_modulus));
		if (input_gaps && $urandom_range(0, 3) == 0) begin
			op_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_random_operation(input int max_exp_bits);
		logic [WIDTH-1:0] b;
		logic [WIDTH-1:0] e;
		int bits;
		case ($urandom_range(0, 9))
			0: b = '0;
			1: b = ALL_ONES;
			2: b = active_modulus - 1;
			3: b = active_modulus;
			default: b = $urandom();
		endcase
		bits = $urandom_range(1, max_exp_bits);
		case ($urandom_range(0, 9))
			0: e = '0;
			1: e = 1;
			2: e = ALL_ONES >> (WIDTH - bits);
			default: e = $urandom() >> (WIDTH - bits);
		endcase
		send_operation(b, e);
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic wait_for_results();
		op_ch.valid <= 1'b0;
		while (expected_powers.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_modulus(input logic [WIDTH-1:0] value);
		wait_for_results();
		@(posedge clk);
		modulus_we <= 1'b1;
		modulus_wdata <= value;
		@(posedge clk);
		modulus_we <= 1'b0;
		active_modulus = value;
	endtask

	task automatic test_reset_modulus();
		send_operation('0, '0);
		send_operation(5, 3);
		send_operation(ALL_ONES, ALL_ONES);
		send_operation(4, '0);
	endtask

	task automatic test_corner_operands();
		write_modulus(PRIME_32);
		send_operation('0, '0);
		send_operation('0, 7);
		send_operation(ALL_ONES, '0);
		send_operation(ALL_ONES, 1);
		send_operation(ALL_ONES, ALL_ONES);
		send_operation(1, ALL_ONES);
		send_operation(PRIME_32 - 1, 2);
		send_operation(PRIME_32, 3);
		send_operation(2, 32);
		send_operation(3, 32'h8000_0000);
		write_modulus(ALL_ONES);
		send_operation(ALL_ONES, 1);
		send_operation(2, 31);
		send_operation(ALL_ONES - 1, ALL_ONES);
		send_operation(32'h1234_5678, 32'hDEAD_BEEF);
		// modulus of one collapses every result to zero
		write_modulus(1);
		send_operation('0, '0);
		send_operation(7, 5);
	endtask

	task automatic test_random_moduli();
		logic [WIDTH-1:0] moduli[8];
		moduli[0] = 7;
		moduli[1] = 65537;
		moduli[2] = 1000;
		moduli[3] = 32'h8000_0000;
		moduli[4] = $urandom_range(2, 1000);
		moduli[5] = $urandom_range(2, ALL_ONES);
		moduli[6] = $urandom_range(2, ALL_ONES);
		moduli[7] = $urandom() | 32'h8000_0001;
		input_gaps = 1'b1;
		output_stalls = 1'b1;
		foreach (moduli[i]) begin
			write_modulus(moduli[i]);
			repeat (25) send_random_operation(WIDTH);
		end
	endtask

	// Hold the output long enough for the core to fill and stall its input.
	task automatic test_output_backpressure();
		write_modulus(PRIME_32);
		hold_requests++;
		@(posedge clk);
		repeat (8) send_random_operation(4);
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		input_gaps = 1'b0;
		output_stalls = 1'b0;
		write_modulus($urandom_range(2, ALL_ONES));
		repeat (60) send_random_operation(WIDTH);
		wait_for_results();
	endtask

	initial begin
		int holds_served;
		holds_served = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				res_ch.ready <= 1'b0;
				repeat (OUTPUT_HOLD_CYCLES - 1) @(posedge clk);
				holds_served++;
			end else if (output_stalls && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_powers.size() == 0) begin
					$error("result: no item expected, got %0d", res_ch.result);
					error_count++;
				end else begin
					oldest_power = expected_powers.pop_front();
					if (res_ch.result !== oldest_power) begin
						$error("result: expected %0d, got %0d", oldest_power, res_ch.result);
						error_count++;
					end
				end
			end
			if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("modular_exponentiation_core_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		modulus_we <= 1'b0;
		modulus_wdata <= '0;
		op_ch.valid <= 1'b0;
		op_ch.base <= '0;
		op_ch.exponent <= '0;
		active_modulus = WIDTH'(mexp_pkg::MODULUS_RESET);
		input_gaps = 1'b1;
		output_stalls = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_modulus();
		test_corner_operands();
		test_random_moduli();
		test_output_backpressure();
		test_back_to_back();

		// catch any stray result after the last one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("modular_exponentiation_core_tb: PASS");
		end else begin
			$display("modular_exponentiation_core_tb: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_if.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation_core.sv
bench/modular_exponentiation_core_tb.sv
